### src/bebo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bebo_pkg: shared types and constants
// Item layouts, register codes, operation codes and field widths used by the
// broadcast element-wise binary operation block.
// ----------------------------------------------------------------------------
package bebo_pkg;

  // Default sizes for the top level parameters.
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int DATA_WIDTH_DEF  = 32;

  // Fixed field widths.
  localparam int TN_W   = 16;
  localparam int TL_W   = 13;
  localparam int TO_W   = 12;
  localparam int LIDX_W = 12;
  localparam int SD_W   = 13;
  localparam int RD_W   = 16;
  localparam int WORD_W = 32;
  // Global index width: tile_number * tile_length + tile_offset fits 29 bits.
  localparam int G_W    = TN_W + TL_W;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_OP  = 3'd0;
  localparam logic [2:0] REG_SD0 = 3'd1;
  localparam logic [2:0] REG_SD1 = 3'd2;
  localparam logic [2:0] REG_SD2 = 3'd3;
  localparam logic [2:0] REG_SD3 = 3'd4;
  localparam logic [2:0] REG_RD0 = 3'd5;
  localparam logic [2:0] REG_RD1 = 3'd6;
  localparam logic [2:0] REG_RD2 = 3'd7;

  // Operation codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Item actions.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [LIDX_W-1:0]        load_index;
    logic signed [WORD_W-1:0] load_value;
    logic [TN_W-1:0]          tile_number;
    logic [TL_W-1:0]          tile_length;
    logic [TO_W-1:0]          tile_offset;
    logic signed [WORD_W-1:0] first_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    logic                     divide_by_zero;
  } out_item_t;

  // Effective dimensions (a zero register acts as one).
  typedef struct packed {
    logic [RD_W-1:0] d0;
    logic [RD_W-1:0] d1;
    logic [RD_W-1:0] d2;
    logic [SD_W-1:0] s0;
    logic [SD_W-1:0] s1;
    logic [SD_W-1:0] s2;
    logic [SD_W-1:0] s3;
  } dims_t;

endpackage

### src/broadcast_elementwise_binary_op_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_elementwise_binary_op_top: broadcast element-wise binary operation
// Signed add, subtract, multiply or divide of a streamed tensor against a
// stored broadcast operand, with four-dimensional broadcasting.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, loads and compute items alike, and
// keeps that rate for as long as results are taken. On its way an item passes
// three one-bit-per-stage dividers that split the 29-bit global index into
// destination coordinates, a four-lane divider that folds them onto the operand
// sizes, and a DATA_WIDTH-stage divider that serves the divide operation. Loads
// pass through the same pipeline and write the store in item order. Load the
// operand words before computing; an entry never loaded reads as an unknown
// value. STORE_DEPTH must be a power of two, which the block itself does not
// enforce. Write the registers only while the block is idle.
module broadcast_elementwise_binary_op_top import bebo_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int QW = 1 + AW + DATA_WIDTH;

  // Configuration registers.
  logic [1:0]      operation_select;
  logic [SD_W-1:0] second_dim0, second_dim1, second_dim2, second_dim3;
  logic [RD_W-1:0] result_dim0, result_dim1, result_dim2;
  logic [2:0]      reg_index;
  logic            wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation_select <= OP_ADD;
      second_dim0 <= SD_W'(1);
      second_dim1 <= SD_W'(1);
      second_dim2 <= SD_W'(1);
      second_dim3 <= SD_W'(1);
      result_dim0 <= RD_W'(1);
      result_dim1 <= RD_W'(1);
      result_dim2 <= RD_W'(1);
    end else if (wr_en) begin
      case (reg_index)
        REG_OP:  operation_select <= pwdata[1:0];
        REG_SD0: second_dim0 <= pwdata[SD_W-1:0];
        REG_SD1: second_dim1 <= pwdata[SD_W-1:0];
        REG_SD2: second_dim2 <= pwdata[SD_W-1:0];
        REG_SD3: second_dim3 <= pwdata[SD_W-1:0];
        REG_RD0: result_dim0 <= pwdata[RD_W-1:0];
        REG_RD1: result_dim1 <= pwdata[RD_W-1:0];
        REG_RD2: result_dim2 <= pwdata[RD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_index)
      REG_OP:  prdata = 32'(operation_select);
      REG_SD0: prdata = 32'(second_dim0);
      REG_SD1: prdata = 32'(second_dim1);
      REG_SD2: prdata = 32'(second_dim2);
      REG_SD3: prdata = 32'(second_dim3);
      REG_RD0: prdata = 32'(result_dim0);
      REG_RD1: prdata = 32'(result_dim1);
      REG_RD2: prdata = 32'(result_dim2);
      default: prdata = '0;
    endcase
  end

  // Effective sizes: a zero size acts as one.
  dims_t dims;

  assign dims.d0 = (result_dim0 == '0) ? RD_W'(1) : result_dim0;
  assign dims.d1 = (result_dim1 == '0) ? RD_W'(1) : result_dim1;
  assign dims.d2 = (result_dim2 == '0) ? RD_W'(1) : result_dim2;
  assign dims.s0 = (second_dim0 == '0) ? SD_W'(1) : second_dim0;
  assign dims.s1 = (second_dim1 == '0) ? SD_W'(1) : second_dim1;
  assign dims.s2 = (second_dim2 == '0) ? SD_W'(1) : second_dim2;
  assign dims.s3 = (second_dim3 == '0) ? SD_W'(1) : second_dim3;

  // Operand strides modulo the store depth.
  logic [2*SD_W-1:0]  p01_full;
  logic [AW+SD_W-1:0] p012_full;
  logic [AW-1:0]      p01, p012;

  assign p01_full  = dims.s0 * dims.s1;
  assign p012_full = p01 * dims.s2;

  always_ff @(posedge clk) begin
    p01  <= AW'(p01_full);
    p012 <= p012_full[AW-1:0];
  end

  // Front, queue and back.
  logic          q_full, q_empty, push, pop;
  logic [QW-1:0] push_data, pop_data;

  bebo_front #(.AW(AW), .DW(DATA_WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .dims(dims), .p01(p01), .p012(p012),
    .q_full(q_full), .push(push), .push_data(push_data)
  );

  bebo_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .pop_data(pop_data), .full(q_full), .empty(q_empty)
  );

  bebo_back #(.STORE_DEPTH(STORE_DEPTH), .AW(AW), .DW(DATA_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(pop_data), .pop(pop),
    .op(operation_select), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

endmodule

### src/bebo_udiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bebo_udiv: pipelined unsigned divider
// Restoring division, one quotient bit per stage, for several lanes that
// share one valid bit, one sideband word and one stage enable.
// ----------------------------------------------------------------------------
module bebo_udiv #(
  parameter int NW    = 29,
  parameter int DV    = 16,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [LANES-1:0][NW-1:0]  num,
  input  logic [LANES-1:0][DV-1:0]  den,
  input  logic [SW-1:0]             side_in,
  output logic                      out_valid,
  output logic [LANES-1:0][NW-1:0]  quot,
  output logic [LANES-1:0][DV-1:0]  rem,
  output logic [SW-1:0]             side_out
);

  logic                     st_v    [0:NW];
  logic [LANES-1:0][NW-1:0] st_num  [0:NW];
  logic [LANES-1:0][DV-1:0] st_rem  [0:NW];
  logic [LANES-1:0][DV-1:0] st_den  [0:NW];
  logic [SW-1:0]            st_side [0:NW];

  assign st_v[0]    = in_valid;
  assign st_num[0]  = num;
  assign st_rem[0]  = '0;
  assign st_den[0]  = den;
  assign st_side[0] = side_in;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [LANES-1:0][NW-1:0] num_next;
    logic [LANES-1:0][DV-1:0] rem_next;

    // One restoring step per lane: shift in the next dividend bit, subtract
    // the divisor where it fits. The divisor travels with its item.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DV:0] trial;
      logic [DV:0] diff;
      logic        fits;
      assign trial = {st_rem[k][l], st_num[k][l][NW-1]};
      assign diff  = trial - {1'b0, st_den[k][l]};
      assign fits  = trial >= {1'b0, st_den[k][l]};
      assign rem_next[l] = fits ? diff[DV-1:0] : trial[DV-1:0];
      assign num_next[l] = {st_num[k][l][NW-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else if (adv) begin
        st_v[k+1] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_num[k+1]  <= num_next;
        st_rem[k+1]  <= rem_next;
        st_den[k+1]  <= st_den[k];
        st_side[k+1] <= st_side[k];
      end
    end
  end

  assign out_valid = st_v[NW];
  assign quot      = st_num[NW];
  assign rem       = st_rem[NW];
  assign side_out  = st_side[NW];

endmodule

### src/bebo_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bebo_front: item intake and address generation
// Accepts items, forms the global index, splits it into destination
// coordinates, folds them onto the broadcast operand and emits store accesses.
// ----------------------------------------------------------------------------
module bebo_front import bebo_pkg::*; #(
  parameter int AW = 12,
  parameter int DW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  input  dims_t            dims,
  input  logic [AW-1:0]    p01,
  input  logic [AW-1:0]    p012,
  input  logic             q_full,
  output logic             push,
  output logic [AW+DW:0]   push_data
);

  localparam int SB_W = 1 + DW + LIDX_W;

  logic adv;
  logic out_v;

  // The whole front moves together; it halts only when its last item cannot
  // enter the queue.
  assign adv      = !(out_v && q_full);
  assign in_stall = !adv;
  assign push     = out_v && adv;

  // Global index stage.
  logic            f0_v;
  logic [G_W-1:0]  f0_g;
  logic [SB_W-1:0] f0_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_v <= 1'b0;
    end else if (adv) begin
      f0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_g  <= in_item.tile_number * in_item.tile_length
               + G_W'(in_item.tile_offset);
      f0_sb <= {in_item.action,
                (in_item.action == ACT_LOAD) ? in_item.load_value[DW-1:0]
                                             : in_item.first_value[DW-1:0],
                in_item.load_index};
    end
  end

  // Coordinate split: three chained divisions by the destination sizes.
  logic            v1, v2, v3;
  logic [G_W-1:0]  q1, q2, q3;
  logic [RD_W-1:0] r1, r2, r3;
  logic [SB_W-1:0] sb1;
  logic [SB_W+RD_W-1:0] sb2;
  logic [SB_W+2*RD_W-1:0] sb3;

  bebo_udiv #(.NW(G_W), .DV(RD_W), .LANES(1), .SW(SB_W)) u_div0 (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(f0_v), .num(f0_g), .den(dims.d0),
    .side_in(f0_sb), .out_valid(v1), .quot(q1), .rem(r1), .side_out(sb1)
  );

  bebo_udiv #(.NW(G_W), .DV(RD_W), .LANES(1), .SW(SB_W+RD_W)) u_div1 (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v1), .num(q1), .den(dims.d1),
    .side_in({sb1, r1}), .out_valid(v2), .quot(q2), .rem(r2), .side_out(sb2)
  );

  bebo_udiv #(.NW(G_W), .DV(RD_W), .LANES(1), .SW(SB_W+2*RD_W)) u_div2 (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v2), .num(q2), .den(dims.d2),
    .side_in({sb2, r2}), .out_valid(v3), .quot(q3), .rem(r3), .side_out(sb3)
  );

  // Broadcast fold: each coordinate modulo the matching operand size.
  logic [3:0][G_W-1:0]  m_num;
  logic [3:0][SD_W-1:0] m_den;
  logic [3:0][SD_W-1:0] m_rem;
  logic                 v4;
  logic [SB_W-1:0]      sb4;

  assign m_num[0] = G_W'(sb3[RD_W +: RD_W]);
  assign m_num[1] = G_W'(sb3[0 +: RD_W]);
  assign m_num[2] = G_W'(r3);
  assign m_num[3] = q3;
  assign m_den    = {dims.s3, dims.s2, dims.s1, dims.s0};

  bebo_udiv #(.NW(G_W), .DV(SD_W), .LANES(4), .SW(SB_W)) u_fold (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v3), .num(m_num), .den(m_den),
    .side_in(sb3[2*RD_W +: SB_W]), .out_valid(v4), .quot(), .rem(m_rem),
    .side_out(sb4)
  );

  // Address terms, all taken modulo the store depth.
  logic [2*SD_W-1:0]    t1_full;
  logic [AW+SD_W-1:0]   t2_full, t3_full;
  logic [AW+SD_W-1:0]   m0_ext;
  logic                 a_v;
  logic [AW-1:0]        a_m0, a_t1, a_t2, a_t3;
  logic [SB_W-1:0]      a_sb;

  assign t1_full = m_rem[1] * dims.s0;
  assign t2_full = m_rem[2] * p01;
  assign t3_full = m_rem[3] * p012;
  assign m0_ext  = {{AW{1'b0}}, m_rem[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_m0 <= m0_ext[AW-1:0];
      a_t1 <= AW'(t1_full);
      a_t2 <= t2_full[AW-1:0];
      a_t3 <= t3_full[AW-1:0];
      a_sb <= sb4;
    end
  end

  // Final address and output register toward the queue.
  logic [AW+LIDX_W-1:0] lidx_ext;
  logic                 o_act;
  logic [AW-1:0]        o_addr;
  logic [DW-1:0]        o_val;

  assign lidx_ext = {{AW{1'b0}}, a_sb[LIDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_act  <= a_sb[SB_W-1];
      o_val  <= a_sb[LIDX_W +: DW];
      o_addr <= (a_sb[SB_W-1] == ACT_LOAD) ? lidx_ext[AW-1:0]
                                           : a_m0 + a_t1 + a_t2 + a_t3;
    end
  end

  assign push_data = {o_act, o_addr, o_val};

endmodule

### src/bebo_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bebo_queue: short queue between front and back
// A small first-in first-out buffer of store accesses.
// ----------------------------------------------------------------------------
module bebo_queue import bebo_pkg::*; #(
  parameter int W = 45
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0]        slots [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PW:0]   count;

  assign full     = count == (QUEUE_PW+1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

### src/bebo_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bebo_back: store access and arithmetic
// Writes loaded words, reads the broadcast operand and computes the selected
// add, subtract, multiply or divide into the output register.
// ----------------------------------------------------------------------------
module bebo_back import bebo_pkg::*; #(
  parameter int STORE_DEPTH = 4096,
  parameter int AW          = 12,
  parameter int DW          = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  logic [AW+DW:0] q_data,
  output logic           pop,
  input  logic [1:0]     op,
  output logic           out_valid,
  input  logic           out_stall,
  output out_item_t      out_item
);

  localparam int SB_W = DW + 3;

  logic          adv;
  logic          q_act;
  logic [AW-1:0] q_addr;
  logic [DW-1:0] q_val;

  // The back halts only while a finished item waits at the output.
  assign adv = !(out_valid && out_stall);
  assign pop = adv && !q_empty;
  assign {q_act, q_addr, q_val} = q_data;

  // Broadcast operand store.
  logic [DW-1:0] store [STORE_DEPTH];
  logic [DW-1:0] rdata;
  logic          b0_v;
  logic [DW-1:0] b0_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop && q_act == ACT_LOAD) store[q_addr] <= q_val;
      rdata <= store[q_addr];
      b0_a  <= q_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
    end else if (adv) begin
      b0_v <= pop && q_act == ACT_COMPUTE;
    end
  end

  // Add, subtract and multiply; operand magnitudes for the divider.
  logic            b1_v;
  logic [DW-1:0]   b1_res;
  logic [DW-1:0]   b1_abs_a, b1_abs_b;
  logic            b1_neg, b1_dz, b1_div;
  logic [2*DW-1:0] prod;
  logic [DW-1:0]   simple;

  assign prod = b0_a * rdata;

  always_comb begin
    case (op)
      OP_ADD:  simple = b0_a + rdata;
      OP_SUB:  simple = b0_a - rdata;
      default: simple = prod[DW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (adv) begin
      b1_v <= b0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_res   <= simple;
      b1_abs_a <= b0_a[DW-1] ? -b0_a : b0_a;
      b1_abs_b <= rdata[DW-1] ? -rdata : rdata;
      b1_neg   <= b0_a[DW-1] ^ rdata[DW-1];
      b1_dz    <= rdata == '0;
      b1_div   <= op == OP_DIV;
    end
  end

  // Magnitude division; everything else rides along in the sideband.
  logic          d_v;
  logic [DW-1:0] d_q;
  logic [DW-1:0] d_r;
  logic [SB_W-1:0] d_sb;
  logic [DW-1:0] s_res;
  logic          s_neg, s_dz, s_div;

  bebo_udiv #(.NW(DW), .DV(DW), .LANES(1), .SW(SB_W)) u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(b1_v), .num(b1_abs_a),
    .den(b1_abs_b), .side_in({b1_res, b1_neg, b1_dz, b1_div}),
    .out_valid(d_v), .quot(d_q), .rem(d_r), .side_out(d_sb)
  );

  assign {s_res, s_neg, s_dz, s_div} = d_sb;

  // Result selection, sign fix-up and sign extension to the word.
  logic [DW-1:0] final_res;

  always_comb begin
    if (!s_div)     final_res = s_res;
    else if (s_dz)  final_res = '0;
    else if (s_neg) final_res = -d_q;
    else            final_res = d_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.result_value   <= WORD_W'($signed(final_res));
      out_item.divide_by_zero <= s_div && s_dz;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: broadcast element-wise binary operation block
// Loads broadcast operand words into the block, then streams element items
// through it. A directed stimulus table covers the extremes, every operation,
// zero divisors and the overflowing quotient. Random phases follow under
// varied register settings and idle patterns. Each result is checked field
// by field against an in-order queue of predicted results.
// ----------------------------------------------------------------------------
module testbench;
  import bebo_pkg::*;

  localparam int DEPTH        = STORE_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 275;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    in_item_t    item;
    bit          typed;
    out_item_t   result;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor state: register copies and the broadcast operand store.
  logic [1:0]  op_sel;
  logic [12:0] sdim [4];
  logic [15:0] rdim [3];
  logic [31:0] operand_store [DEPTH];
  bit          operand_loaded [DEPTH];

  out_item_t   result_queue [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_pct = 0;
  int          recv_pct = 0;
  int          hold_at = -1;
  int          hold_left = 0;
  stim_row_t   directed [$];

  broadcast_elementwise_binary_op_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL broadcast_elementwise_binary_op_top");
      $finish;
    end
  end

  // Receiver stall: random idling, or a long hold-off once requested.
  always @(posedge clk) begin
    if (cycle_count == hold_at) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (result_queue.size() == 0) begin
        report_mismatch("unexpected result", out_item.result_value, '0);
      end else begin
        want = result_queue.pop_front();
        if (out_item.result_value !== want.result_value)
          report_mismatch("result_value", out_item.result_value, want.result_value);
        if (out_item.divide_by_zero !== want.divide_by_zero)
          report_mismatch("divide_by_zero", 32'(out_item.divide_by_zero),
                          32'(want.divide_by_zero));
      end
    end
  end

  function automatic longint unsigned dim_eff(longint unsigned d);
    return (d == 0) ? 1 : d;
  endfunction

  // Store address of the broadcast operand for one element item.
  function automatic int operand_address(in_item_t it);
    longint unsigned g, d0, d1, d2, s0, s1, s2, s3, c0, c1, c2, c3, addr;
    g  = longint'(it.tile_number) * longint'(it.tile_length) + longint'(it.tile_offset);
    d0 = dim_eff(rdim[0]);
    d1 = dim_eff(rdim[1]);
    d2 = dim_eff(rdim[2]);
    s0 = dim_eff(sdim[0]);
    s1 = dim_eff(sdim[1]);
    s2 = dim_eff(sdim[2]);
    s3 = dim_eff(sdim[3]);
    c0 = g % d0;
    c1 = (g / d0) % d1;
    c2 = (g / (d0 * d1)) % d2;
    c3 = g / (d0 * d1 * d2);
    addr = (c0 % s0) + (c1 % s1) * s0 + (c2 % s2) * s0 * s1 + (c3 % s3) * s0 * s1 * s2;
    return int'(addr % DEPTH);
  endfunction

  // Applies one item to the predictor state; returns 1 with the result if any.
  function automatic bit compute_element(in_item_t it, output out_item_t res);
    longint a, b, r;
    res = '0;
    if (it.action == ACT_LOAD) begin
      operand_store[it.load_index] = it.load_value;
      operand_loaded[it.load_index] = 1'b1;
      return 1'b0;
    end
    a = longint'(signed'(it.first_value));
    b = longint'(signed'(operand_store[operand_address(it)]));
    r = 0;
    case (op_sel)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      default: begin
        if (b == 0) res.divide_by_zero = 1'b1;
        else r = a / b;
      end
    endcase
    res.result_value = r[31:0];
    return 1'b1;
  endfunction

  // Offers one item to the block and waits until it is accepted.
  task automatic offer_item(in_item_t it);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends an item; an element item whose operand was never loaded gets one first.
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    in_item_t  fill;
    out_item_t res;
    int        addr;
    if (it.action == ACT_COMPUTE) begin
      addr = operand_address(it);
      if (!operand_loaded[addr]) begin
        fill = '0;
        fill.action = ACT_LOAD;
        fill.load_index = addr[LIDX_W-1:0];
        fill.load_value = $urandom();
        void'(compute_element(fill, res));
        offer_item(fill);
      end
    end
    if (compute_element(it, res))
      result_queue.push_back(typed ? typed_res : res);
    offer_item(it);
  endtask

  // Lowers valid and waits until every predicted result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OP:  op_sel = value[1:0];
      REG_SD0: sdim[0] = value[12:0];
      REG_SD1: sdim[1] = value[12:0];
      REG_SD2: sdim[2] = value[12:0];
      REG_SD3: sdim[3] = value[12:0];
      REG_RD0: rdim[0] = value[15:0];
      REG_RD1: rdim[1] = value[15:0];
      default: rdim[2] = value[15:0];
    endcase
  endtask

  function automatic stim_row_t cfg_row(logic [2:0] idx, logic [31:0] value);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t load_row(logic [11:0] idx, logic [31:0] value);
    stim_row_t r;
    r = '{default: '0};
    r.item.action = ACT_LOAD;
    r.item.load_index = idx;
    r.item.load_value = value;
    return r;
  endfunction

  function automatic stim_row_t elem_row(logic [15:0] tn, logic [12:0] tl, logic [11:0] to,
                                         logic [31:0] first, bit typed,
                                         logic [31:0] want, logic dz);
    stim_row_t r;
    r = '{default: '0};
    r.item.action = ACT_COMPUTE;
    r.item.tile_number = tn;
    r.item.tile_length = tl;
    r.item.tile_offset = to;
    r.item.first_value = first;
    r.typed = typed;
    r.result.result_value = want;
    r.result.divide_by_zero = dz;
    return r;
  endfunction

  // Random operand word: extremes, zero, small or anything.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return 32'hFFFF_FFFF;
      4, 5: return 32'($urandom_range(20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it = '0;
    it.action = ($urandom_range(99) < 25) ? ACT_LOAD : ACT_COMPUTE;
    it.load_index = $urandom();
    it.load_value = rand_word();
    if ($urandom_range(3) == 0) begin
      it.tile_number = $urandom();
      it.tile_length = $urandom();
      it.tile_offset = $urandom();
    end else begin
      it.tile_number = $urandom_range(40);
      it.tile_length = $urandom_range(64, 1);
      it.tile_offset = $urandom_range(63);
    end
    it.first_value = rand_word();
    return it;
  endfunction

  function automatic logic [31:0] rand_sdim(int phase);
    if (phase == PHASES - 1) return 32'd4096;
    case ($urandom_range(9))
      0: return '0;
      1: return 32'h1FFF;
      2: return 32'd4096;
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  function automatic logic [31:0] rand_rdim(int phase);
    if (phase == PHASES - 1) return 32'd65535;
    case ($urandom_range(9))
      0: return '0;
      1: return 32'hFFFF;
      default: return $urandom_range(12, 1);
    endcase
  endfunction

  initial begin
    stim_row_t row;
    op_sel = OP_ADD;
    for (int i = 0; i < 4; i++) sdim[i] = 13'd1;
    for (int i = 0; i < 3; i++) rdim[i] = 16'd1;
    for (int i = 0; i < DEPTH; i++) begin
      operand_store[i] = '0;
      operand_loaded[i] = 1'b0;
    end

    // With every dimension at one, all elements read store entry zero.
    directed.push_back(load_row(12'd0, 32'd5));
    directed.push_back(load_row(12'hFFF, 32'hFFFF_FFFF));
    directed.push_back(elem_row(16'd0, 13'd1, 12'd0, 32'd7, 1, 32'd12, 0));
    directed.push_back(elem_row(16'd0, 13'd1, 12'd0, 32'h7FFF_FFFF, 1, 32'h8000_0004, 0));
    directed.push_back(elem_row(16'hFFFF, 13'h1FFF, 12'hFFF, 32'hFFFF_FFF8, 1,
                                32'hFFFF_FFFD, 0));
    directed.push_back(cfg_row(REG_OP, OP_SUB));
    directed.push_back(elem_row(16'd3, 13'd2, 12'd1, 32'h8000_0000, 1, 32'h7FFF_FFFB, 0));
    directed.push_back(cfg_row(REG_OP, OP_MUL));
    directed.push_back(elem_row(16'd0, 13'd1, 12'd0, 32'h4000_0000, 1, 32'h4000_0000, 0));
    directed.push_back(cfg_row(REG_OP, OP_DIV));
    directed.push_back(elem_row(16'd0, 13'd1, 12'd0, 32'hFFFF_FFF9, 1, 32'hFFFF_FFFF, 0));
    // Zero divisor.
    directed.push_back(load_row(12'd0, 32'd0));
    directed.push_back(elem_row(16'd0, 13'd1, 12'd0, 32'd9, 1, 32'd0, 1));
    // Most negative value divided by minus one wraps.
    directed.push_back(load_row(12'd0, 32'hFFFF_FFFF));
    directed.push_back(elem_row(16'd0, 13'd1, 12'd0, 32'h8000_0000, 1, 32'h8000_0000, 0));
    // Zero dimension registers act as one; offsets beyond the tile length.
    directed.push_back(cfg_row(REG_SD0, 32'd0));
    directed.push_back(cfg_row(REG_RD0, 32'd0));
    directed.push_back(elem_row(16'd2, 13'd1, 12'd100, 32'd11, 1, 32'hFFFF_FFF5, 0));
    // Largest innermost sizes reach the top store entry.
    directed.push_back(cfg_row(REG_SD0, 32'd4096));
    directed.push_back(cfg_row(REG_RD0, 32'd65535));
    directed.push_back(elem_row(16'd0, 13'd1, 12'hFFF, 32'h7FFF_FFFF, 0, '0, 0));
    directed.push_back(elem_row(16'd1, 13'd4096, 12'd0, 32'd1000, 0, '0, 0));
    directed.push_back(load_row(12'd4, 32'h8000_0000));
    directed.push_back(elem_row(16'd1, 13'd2, 12'd2, 32'h8000_0000, 0, '0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed[i]) begin
      row = directed[i];
      if (row.is_cfg) begin
        drain();
        write_register(row.reg_idx, row.value);
      end else begin
        send_item(row.item, row.typed, row.result);
      end
    end

    // Random phases, each under its own register setting and idle pattern.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_register(REG_OP, 32'(p % 4) ^ 32'($urandom_range(1) * 2 * (p / 4)));
      write_register(REG_SD0, rand_sdim(p));
      write_register(REG_SD1, rand_sdim(p));
      write_register(REG_SD2, rand_sdim(p));
      write_register(REG_SD3, rand_sdim(p));
      write_register(REG_RD0, rand_rdim(p));
      write_register(REG_RD1, rand_rdim(p));
      write_register(REG_RD2, rand_rdim(p));
      send_pct = (p < 2) ? 7 : (p < 4) ? 71 : 0;
      recv_pct = (p < 2) ? 71 : (p < 4) ? 7 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Receiver holds off long enough to back up the pipeline.
        if (p == 4 && n == 20) hold_at = cycle_count + 2;
        // Sender pauses until every result so far has come back.
        if (p == 2 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (result_queue.size() != 0) @(posedge clk);
        end
        send_item(rand_item(), 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS broadcast_elementwise_binary_op_top");
    end else begin
      $display("FAIL broadcast_elementwise_binary_op_top");
    end
    $finish;
  end

endmodule

### broadcast_elementwise_binary_op_top.f
src/bebo_pkg.sv
src/bebo_udiv.sv
src/bebo_front.sv
src/bebo_queue.sv
src/bebo_back.sv
src/broadcast_elementwise_binary_op_top.sv
tb/testbench.sv
